### hw/rtl/cppg_pkg.sv
// ----------------------------------------------------------------------------
// cppg_pkg
// Shared constants and types of the colour plane palette generator.
// ----------------------------------------------------------------------------
package cppg_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CH_MAX    = 255;
  localparam int SECTORS   = 6;
  localparam int HUE_MAX   = 360;
  localparam int HUE_STEP  = 60;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // pattern modes
  localparam logic [2:0] MODE_RED   = 3'd0;
  localparam logic [2:0] MODE_GREEN = 3'd1;
  localparam logic [2:0] MODE_BLUE  = 3'd2;
  localparam logic [2:0] MODE_HUE   = 3'd3;
  localparam logic [2:0] MODE_SAT   = 3'd4;
  localparam logic [2:0] MODE_VALUE = 3'd5;

  // register indexes
  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_RED        = 3'd1;
  localparam logic [2:0] REG_GREEN      = 3'd2;
  localparam logic [2:0] REG_BLUE       = 3'd3;
  localparam logic [2:0] REG_HUE        = 3'd4;
  localparam logic [2:0] REG_SATURATION = 3'd5;
  localparam logic [2:0] REG_BRIGHTNESS = 3'd6;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

endpackage

### hw/rtl/cppg_cdiv.sv
// ----------------------------------------------------------------------------
// cppg_cdiv
// Three-stage unsigned division by a constant: reciprocal multiply, back
// multiply, then a single remainder correction.
// ----------------------------------------------------------------------------
module cppg_cdiv #(
  parameter int NW      = 18,
  parameter int QW      = 8,
  parameter int DIVISOR = 1
) (
  input  logic          clk,
  input  logic [2:0]    en,
  input  logic [NW-1:0] num,
  output logic [QW-1:0] quo
);

  localparam int RW = NW + 1;
  localparam int PW = NW + RW;
  localparam logic [RW-1:0] RECIP = RW'((65'd1 << NW) / DIVISOR);

  logic [PW-1:0] prod;
  logic [NW-1:0] num_a;
  logic [NW-1:0] num_b;
  logic [NW-1:0] qd_b;
  logic [QW-1:0] qe_b;
  logic [QW-1:0] q_est;
  logic [NW-1:0] rem;

  assign q_est = prod[NW +: QW];
  assign rem   = num_b - qd_b;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod  <= PW'(num) * PW'(RECIP);
      num_a <= num;
    end
    if (en[1]) begin
      qe_b  <= q_est;
      qd_b  <= NW'(q_est) * NW'(DIVISOR);
      num_b <= num_a;
    end
    if (en[2]) begin
      quo <= qe_b + QW'(rem >= NW'(DIVISOR));
    end
  end

endmodule

### hw/rtl/cppg_hsv.sv
// ----------------------------------------------------------------------------
// cppg_hsv
// Four-stage HSV to RGB datapath in Q16, with the final choice between the
// HSV colour and the plain RGB plane colour.
// ----------------------------------------------------------------------------
module cppg_hsv (
  input  logic             clk,
  input  logic [3:0]       en,
  input  logic [2:0]       mode,
  input  logic [18:0]      hp,
  input  logic [16:0]      sat,
  input  logic [16:0]      val,
  input  cppg_pkg::pixel_t bypass,
  output cppg_pkg::pixel_t pixel
);

  logic [33:0] sv_prod;
  logic [16:0] m_frac;
  logic [16:0] dev;
  logic [2:0]  sector_raw;
  logic [16:0] c_a;
  logic [16:0] d_a;
  logic [16:0] v_a;
  logic [2:0]  sector_a;
  cppg_pkg::pixel_t bypass_a;
  logic [33:0] x_prod;
  logic [16:0] x_b;
  logic [16:0] lo_b;
  logic [16:0] v_b;
  logic [2:0]  sector_b;
  cppg_pkg::pixel_t bypass_b;
  logic [16:0] mid;
  logic [16:0] r_c;
  logic [16:0] g_c;
  logic [16:0] b_c;
  cppg_pkg::pixel_t bypass_c;
  logic [7:0]  r_byte;
  logic [7:0]  g_byte;
  logic [7:0]  b_byte;
  logic        is_hsv;

  function automatic logic [7:0] to_byte(input logic [16:0] q);
    logic [24:0] scaled;
    scaled = {q, 8'b0} - 25'(q);
    return (scaled[24:16] > 9'(cppg_pkg::CH_MAX)) ? 8'(cppg_pkg::CH_MAX) : scaled[23:16];
  endfunction

  assign sv_prod    = 34'(sat) * 34'(val);
  assign m_frac     = hp[16:0];
  assign dev        = (m_frac >= cppg_pkg::ONE_Q16) ? m_frac - cppg_pkg::ONE_Q16
                                                    : cppg_pkg::ONE_Q16 - m_frac;
  assign sector_raw = hp[18:16];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      c_a      <= sv_prod[32:16];
      d_a      <= dev;
      v_a      <= val;
      sector_a <= (sector_raw > 3'(cppg_pkg::SECTORS - 1)) ? 3'(cppg_pkg::SECTORS - 1)
                                                            : sector_raw;
      bypass_a <= bypass;
    end
  end

  assign x_prod = 34'(c_a) * 34'(cppg_pkg::ONE_Q16 - d_a);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x_b      <= x_prod[32:16];
      lo_b     <= v_a - c_a;
      v_b      <= v_a;
      sector_b <= sector_a;
      bypass_b <= bypass_a;
    end
  end

  assign mid = x_b + lo_b;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      case (sector_b)
        3'd0: begin
          r_c <= v_b;  g_c <= mid;  b_c <= lo_b;
        end
        3'd1: begin
          r_c <= mid;  g_c <= v_b;  b_c <= lo_b;
        end
        3'd2: begin
          r_c <= lo_b; g_c <= v_b;  b_c <= mid;
        end
        3'd3: begin
          r_c <= lo_b; g_c <= mid;  b_c <= v_b;
        end
        3'd4: begin
          r_c <= mid;  g_c <= lo_b; b_c <= v_b;
        end
        default: begin
          r_c <= v_b;  g_c <= lo_b; b_c <= mid;
        end
      endcase
      bypass_c <= bypass_b;
    end
  end

  assign r_byte = to_byte(r_c);
  assign g_byte = to_byte(g_c);
  assign b_byte = to_byte(b_c);
  assign is_hsv = (mode == cppg_pkg::MODE_HUE) || (mode == cppg_pkg::MODE_SAT) ||
                  (mode == cppg_pkg::MODE_VALUE);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      if (is_hsv) begin
        pixel.red   <= r_byte;
        pixel.green <= g_byte;
        pixel.blue  <= b_byte;
      end else begin
        pixel <= bypass_c;
      end
    end
  end

endmodule

### hw/rtl/color_plane_palette_generator.sv
// ----------------------------------------------------------------------------
// color_plane_palette_generator
// Gives the RGB colour of one pixel of a palette plane chosen by mode.
// ----------------------------------------------------------------------------
// One item enters per clock unless a stalled output backs up to the input, and
// its colour is offered from the last of eight register stages: one stage
// clamps the coordinates, three stages divide by constants (plane size less
// one, hue step, channel maximum) through reciprocal multipliers, and four
// stages run the HSV to RGB datapath. Every stage moves on its own, so a
// stalled output only holds back stages that are full. Configuration writes
// are taken in every cycle and must only be made while no item is in flight.
module color_plane_palette_generator #(
  parameter int PLANE_WIDTH  = 1024,
  parameter int PLANE_HEIGHT = 768
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // pixel_column, pixel_row, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int W_DIV  = (PLANE_WIDTH > 2) ? PLANE_WIDTH - 1 : 1;
  localparam int H_DIV  = (PLANE_HEIGHT > 2) ? PLANE_HEIGHT - 1 : 1;
  localparam int STAGES = 8;

  logic [2:0] pattern_mode;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;
  logic [8:0] hue_degrees;
  logic [7:0] saturation_level;
  logic [7:0] brightness_level;

  logic [STAGES-1:0] valid;
  logic [STAGES-1:0] en;

  logic [9:0]  pixel_column;
  logic [9:0]  pixel_row;
  logic [9:0]  col_c;
  logic [9:0]  row_c;
  logic [8:0]  hue_c;

  logic [7:0]  col_ch;
  logic [7:0]  row_ch;
  logic [16:0] col_q;
  logic [16:0] row_q;
  logic [18:0] col_hp;
  logic [18:0] hue_hp;
  logic [16:0] sat_q;
  logic [16:0] bri_q;

  logic [18:0] hp_sel;
  logic [16:0] sat_sel;
  logic [16:0] val_sel;
  cppg_pkg::pixel_t bypass;
  cppg_pkg::pixel_t pixel;

  assign pixel_column = s_axis_tdata[9:0];
  assign pixel_row    = s_axis_tdata[19:10];

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mode     <= cppg_pkg::MODE_RED;
      red_level        <= '0;
      green_level      <= '0;
      blue_level       <= '0;
      hue_degrees      <= '0;
      saturation_level <= '0;
      brightness_level <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cppg_pkg::REG_MODE:       pattern_mode     <= cfg_data[2:0];
        cppg_pkg::REG_RED:        red_level        <= cfg_data[7:0];
        cppg_pkg::REG_GREEN:      green_level      <= cfg_data[7:0];
        cppg_pkg::REG_BLUE:       blue_level       <= cfg_data[7:0];
        cppg_pkg::REG_HUE:        hue_degrees      <= cfg_data;
        cppg_pkg::REG_SATURATION: saturation_level <= cfg_data[7:0];
        cppg_pkg::REG_BRIGHTNESS: brightness_level <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  always_comb begin
    en[STAGES-1] = !valid[STAGES-1] || m_axis_tready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = valid[STAGES-1];

  // clamp stage
  always_ff @(posedge clk) begin
    if (en[0]) begin
      col_c <= (13'(pixel_column) > 13'(W_DIV)) ? 10'(W_DIV) : pixel_column;
      row_c <= (13'(pixel_row) > 13'(H_DIV)) ? 10'(H_DIV) : pixel_row;
      hue_c <= (hue_degrees > 9'(cppg_pkg::HUE_MAX)) ? 9'(cppg_pkg::HUE_MAX) : hue_degrees;
    end
  end

  // dividers
  cppg_cdiv #(.NW(18), .QW(8), .DIVISOR(W_DIV)) u_col_ch (
    .clk(clk), .en(en[3:1]),
    .num(18'(col_c) * 18'(cppg_pkg::CH_MAX)), .quo(col_ch)
  );

  cppg_cdiv #(.NW(18), .QW(8), .DIVISOR(H_DIV)) u_row_ch (
    .clk(clk), .en(en[3:1]),
    .num(18'(row_c) * 18'(cppg_pkg::CH_MAX)), .quo(row_ch)
  );

  cppg_cdiv #(.NW(26), .QW(17), .DIVISOR(W_DIV)) u_col_q (
    .clk(clk), .en(en[3:1]), .num({col_c, 16'b0}), .quo(col_q)
  );

  cppg_cdiv #(.NW(26), .QW(17), .DIVISOR(H_DIV)) u_row_q (
    .clk(clk), .en(en[3:1]), .num({row_c, 16'b0}), .quo(row_q)
  );

  cppg_cdiv #(.NW(29), .QW(19), .DIVISOR(W_DIV)) u_col_hp (
    .clk(clk), .en(en[3:1]),
    .num({13'(col_c) * 13'(cppg_pkg::SECTORS), 16'b0}), .quo(col_hp)
  );

  cppg_cdiv #(.NW(25), .QW(19), .DIVISOR(cppg_pkg::HUE_STEP)) u_hue_hp (
    .clk(clk), .en(en[3:1]), .num({hue_c, 16'b0}), .quo(hue_hp)
  );

  cppg_cdiv #(.NW(24), .QW(17), .DIVISOR(cppg_pkg::CH_MAX)) u_sat_q (
    .clk(clk), .en(en[3:1]), .num({saturation_level, 16'b0}), .quo(sat_q)
  );

  cppg_cdiv #(.NW(24), .QW(17), .DIVISOR(cppg_pkg::CH_MAX)) u_bri_q (
    .clk(clk), .en(en[3:1]), .num({brightness_level, 16'b0}), .quo(bri_q)
  );

  // mode selection
  always_comb begin
    hp_sel  = col_hp;
    sat_sel = col_q;
    val_sel = row_q;
    bypass  = '0;
    case (pattern_mode)
      cppg_pkg::MODE_RED: begin
        bypass.red   = red_level;
        bypass.green = row_ch;
        bypass.blue  = col_ch;
      end
      cppg_pkg::MODE_GREEN: begin
        bypass.red   = row_ch;
        bypass.green = green_level;
        bypass.blue  = col_ch;
      end
      cppg_pkg::MODE_BLUE: begin
        bypass.red   = row_ch;
        bypass.green = col_ch;
        bypass.blue  = blue_level;
      end
      cppg_pkg::MODE_HUE: begin
        hp_sel  = hue_hp;
        sat_sel = col_q;
        val_sel = row_q;
      end
      cppg_pkg::MODE_SAT: begin
        hp_sel  = col_hp;
        sat_sel = sat_q;
        val_sel = row_q;
      end
      cppg_pkg::MODE_VALUE: begin
        hp_sel  = col_hp;
        sat_sel = row_q;
        val_sel = bri_q;
      end
      default: ;
    endcase
  end

  cppg_hsv u_hsv (
    .clk   (clk),
    .en    (en[7:4]),
    .mode  (pattern_mode),
    .hp    (hp_sel),
    .sat   (sat_sel),
    .val   (val_sel),
    .bypass(bypass),
    .pixel (pixel)
  );

  assign m_axis_tdata = {pixel.blue, pixel.green, pixel.red};

endmodule

### hw/rtl/cppg_checker.sv
// ----------------------------------------------------------------------------
// cppg_checker
// Port-level checks of the colour plane palette generator.
// ----------------------------------------------------------------------------
module cppg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [2:0]  cfg_index,
  input logic [8:0]  cfg_data
);

  logic [2:0] mode_seen;
  logic [7:0] red_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_seen <= cppg_pkg::MODE_RED;
      red_seen  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == cppg_pkg::REG_MODE) begin
        mode_seen <= cfg_data[2:0];
      end
      if (cfg_index == cppg_pkg::REG_RED) begin
        red_seen <= cfg_data[7:0];
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output");

  a_unused_black: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (mode_seen > cppg_pkg::MODE_VALUE) |-> m_axis_tdata == 24'd0)
    else $error("unused mode gave a colour");

  a_red_fixed: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (mode_seen == cppg_pkg::MODE_RED) |-> m_axis_tdata[7:0] == red_seen)
    else $error("red not held fixed in red mode");

endmodule

bind color_plane_palette_generator cppg_checker u_cppg_checker (.*);

### tb/sv/tb_color_plane_palette_generator.sv
// ----------------------------------------------------------------------------
// tb_color_plane_palette_generator
// Self-checking bench for the colour plane palette generator.
// A short table of directed pixels and register writes comes first. It covers
// every plane mode, the unused mode codes, the plane corners, coordinates
// past the plane edge and hue above 360. Random register settings and random
// pixels follow under varied source and sink back-pressure, with one long
// sink hold that fills the pipeline. Every colour is compared channel by
// channel against its typed value or a Q16 fixed-point model of the plane.
// ----------------------------------------------------------------------------
module tb_color_plane_palette_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import cppg_pkg::*;

  localparam int PLANE_W    = 1024;
  localparam int PLANE_H    = 768;
  localparam int PIPE_DEPTH = 8;
  localparam int LONG_HOLD  = 200;
  localparam int SEGMENTS   = 10;
  localparam int SEG_ITEMS  = 95;

  localparam longint unsigned UNIT_Q16 = 64'd65536;
  localparam longint unsigned W_DIV    = PLANE_W - 1;
  localparam longint unsigned H_DIV    = PLANE_H - 1;

  typedef enum logic {STEP_WRITE, STEP_PIXEL} step_kind_t;

  typedef struct packed {
    step_kind_t kind;
    logic [2:0] idx;
    logic [8:0] val;
    logic [9:0] col;
    logic [9:0] row;
    logic       typed;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } step_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // pixel_column, pixel_row, zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // red_out, green_out, blue_out
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [8:0]  cfg_data;

  // register copies
  logic [2:0] plane_mode;
  logic [7:0] red_lvl;
  logic [7:0] green_lvl;
  logic [7:0] blue_lvl;
  logic [8:0] hue_deg;
  logic [7:0] sat_lvl;
  logic [7:0] bright_lvl;

  pixel_t colour_q[$];
  int     src_idle_pct;
  int     sink_stall_pct;
  bit     long_hold;
  int     mismatches;
  int     colours_checked;
  int     pixels_sent;
  int     writes_done;

  // directed table: typed colours only where they follow at a glance
  step_t plan[$] = '{
    '{STEP_PIXEL, REG_MODE,       9'd0,   10'd0,    10'd0,    1'b1, 8'd0,   8'd0,   8'd0},
    '{STEP_PIXEL, REG_MODE,       9'd0,   10'd1023, 10'd767,  1'b1, 8'd0,   8'd255, 8'd255},
    '{STEP_PIXEL, REG_MODE,       9'd0,   10'd1023, 10'd1023, 1'b1, 8'd0,   8'd255, 8'd255},
    '{STEP_PIXEL, REG_MODE,       9'd0,   10'd512,  10'd300,  1'b0, 8'd0,   8'd0,   8'd0},
    '{STEP_WRITE, REG_RED,        9'd255, 10'd0,    10'd0,    1'b0, 8'd0,   8'd0,   8'd0},
    '{STEP_PIXEL, REG_MODE,       9'd0,   10'd0,    10'd0,    1'b1, 8'd255, 8'd0,   8'd0},
    '{STEP_WRITE, REG_MODE,       9'(MODE_GREEN), 10'd0, 10'd0, 1'b0, 8'd0, 8'd0,   8'd0},
    '{STEP_WRITE, REG_GREEN,      9'd128, 10'd0,    10'd0,    1'b0, 8'd0,   8'd0,   8'd0},
    '{STEP_PIXEL, REG_MODE,       9'd0,   10'd1023, 10'd0,    1'b1, 8'd0,   8'd128, 8'd255},
    '{STEP_PIXEL, REG_MODE,       9'd0,   10'd700,  10'd500,  1'b0, 8'd0,   8'd0,   8'd0},
    '{STEP_WRITE, REG_MODE,       9'(MODE_BLUE), 10'd0, 10'd0, 1'b0, 8'd0,  8'd0,   8'd0},
    '{STEP_WRITE, REG_BLUE,       9'd77,  10'd0,    10'd0,    1'b0, 8'd0,   8'd0,   8'd0},
    '{STEP_PIXEL, REG_MODE,       9'd0,   10'd0,    10'd767,  1'b1, 8'd255, 8'd0,   8'd77},
    '{STEP_WRITE, REG_MODE,       9'(MODE_HUE), 10'd0, 10'd0, 1'b0, 8'd0,   8'd0,   8'd0},
    '{STEP_WRITE, REG_HUE,        9'd0,   10'd0,    10'd0,    1'b0, 8'd0,   8'd0,   8'd0},
    '{STEP_PIXEL, REG_MODE,       9'd0,   10'd1023, 10'd767,  1'b1, 8'd255, 8'd0,   8'd0},
    '{STEP_PIXEL, REG_MODE,       9'd0,   10'd1023, 10'd0,    1'b1, 8'd0,   8'd0,   8'd0},
    '{STEP_WRITE, REG_HUE,        9'd120, 10'd0,    10'd0,    1'b0, 8'd0,   8'd0,   8'd0},
    '{STEP_PIXEL, REG_MODE,       9'd0,   10'd1023, 10'd767,  1'b1, 8'd0,   8'd255, 8'd0},
    '{STEP_PIXEL, REG_MODE,       9'd0,   10'd400,  10'd600,  1'b0, 8'd0,   8'd0,   8'd0},
    '{STEP_WRITE, REG_HUE,        9'd511, 10'd0,    10'd0,    1'b0, 8'd0,   8'd0,   8'd0},
    '{STEP_PIXEL, REG_MODE,       9'd0,   10'd1023, 10'd767,  1'b1, 8'd255, 8'd0,   8'd0},
    '{STEP_WRITE, REG_HUE,        9'd360, 10'd0,    10'd0,    1'b0, 8'd0,   8'd0,   8'd0},
    '{STEP_PIXEL, REG_MODE,       9'd0,   10'd600,  10'd400,  1'b0, 8'd0,   8'd0,   8'd0},
    '{STEP_WRITE, REG_MODE,       9'(MODE_SAT), 10'd0, 10'd0, 1'b0, 8'd0,   8'd0,   8'd0},
    '{STEP_WRITE, REG_SATURATION, 9'd0,   10'd0,    10'd0,    1'b0, 8'd0,   8'd0,   8'd0},
    '{STEP_PIXEL, REG_MODE,       9'd0,   10'd1023, 10'd767,  1'b1, 8'd255, 8'd255, 8'd255},
    '{STEP_WRITE, REG_SATURATION, 9'd255, 10'd0,    10'd0,    1'b0, 8'd0,   8'd0,   8'd0},
    '{STEP_PIXEL, REG_MODE,       9'd0,   10'd0,    10'd767,  1'b1, 8'd255, 8'd0,   8'd0},
    '{STEP_PIXEL, REG_MODE,       9'd0,   10'd1023, 10'd1023, 1'b0, 8'd0,   8'd0,   8'd0},
    '{STEP_PIXEL, REG_MODE,       9'd0,   10'd341,  10'd767,  1'b0, 8'd0,   8'd0,   8'd0},
    '{STEP_WRITE, REG_MODE,       9'(MODE_VALUE), 10'd0, 10'd0, 1'b0, 8'd0, 8'd0,   8'd0},
    '{STEP_WRITE, REG_BRIGHTNESS, 9'd0,   10'd0,    10'd0,    1'b0, 8'd0,   8'd0,   8'd0},
    '{STEP_PIXEL, REG_MODE,       9'd0,   10'd555,  10'd333,  1'b1, 8'd0,   8'd0,   8'd0},
    '{STEP_WRITE, REG_BRIGHTNESS, 9'd255, 10'd0,    10'd0,    1'b0, 8'd0,   8'd0,   8'd0},
    '{STEP_PIXEL, REG_MODE,       9'd0,   10'd0,    10'd0,    1'b1, 8'd255, 8'd255, 8'd255},
    '{STEP_PIXEL, REG_MODE,       9'd0,   10'd0,    10'd767,  1'b1, 8'd255, 8'd0,   8'd0},
    '{STEP_PIXEL, REG_MODE,       9'd0,   10'd1023, 10'd900,  1'b0, 8'd0,   8'd0,   8'd0},
    '{STEP_WRITE, REG_MODE,       9'd6,   10'd0,    10'd0,    1'b0, 8'd0,   8'd0,   8'd0},
    '{STEP_PIXEL, REG_MODE,       9'd0,   10'd1023, 10'd767,  1'b1, 8'd0,   8'd0,   8'd0},
    '{STEP_WRITE, REG_MODE,       9'd7,   10'd0,    10'd0,    1'b0, 8'd0,   8'd0,   8'd0},
    '{STEP_PIXEL, REG_MODE,       9'd0,   10'd5,    10'd5,    1'b1, 8'd0,   8'd0,   8'd0}
  };

  color_plane_palette_generator #(
    .PLANE_WIDTH (PLANE_W),
    .PLANE_HEIGHT(PLANE_H)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [7:0] q16_to_byte(input longint unsigned q);
    longint unsigned v;
    v = (q * CH_MAX) >> 16;
    return (v > CH_MAX) ? 8'd255 : v[7:0];
  endfunction

  // six-sector hsv rule, all operands q16
  function automatic pixel_t hsv_colour(input longint unsigned hp, sat, val);
    longint unsigned chroma, pos, dev, x, sector, lo, mid, r, g, b;
    pixel_t px;
    chroma = (sat * val) >> 16;
    pos    = hp & (2 * UNIT_Q16 - 1);
    dev    = (pos >= UNIT_Q16) ? pos - UNIT_Q16 : UNIT_Q16 - pos;
    x      = (chroma * (UNIT_Q16 - dev)) >> 16;
    sector = hp >> 16;
    if (sector > SECTORS - 1) sector = SECTORS - 1;
    lo  = val - chroma;
    mid = x + val - chroma;
    case (sector)
      0: begin r = val; g = mid; b = lo;  end
      1: begin r = mid; g = val; b = lo;  end
      2: begin r = lo;  g = val; b = mid; end
      3: begin r = lo;  g = mid; b = val; end
      4: begin r = mid; g = lo;  b = val; end
      default: begin r = val; g = lo; b = mid; end
    endcase
    px.red   = q16_to_byte(r);
    px.green = q16_to_byte(g);
    px.blue  = q16_to_byte(b);
    return px;
  endfunction

  function automatic pixel_t predict_colour(input logic [9:0] col_in, row_in);
    longint unsigned col, row, col_q, row_q, hp, hue;
    logic [7:0] col_ch, row_ch;
    pixel_t px;
    col    = (col_in > W_DIV) ? W_DIV : col_in;
    row    = (row_in > H_DIV) ? H_DIV : row_in;
    col_ch = 8'((col * CH_MAX) / W_DIV);
    row_ch = 8'((row * CH_MAX) / H_DIV);
    col_q  = (col * UNIT_Q16) / W_DIV;
    row_q  = (row * UNIT_Q16) / H_DIV;
    hp     = (col * SECTORS * UNIT_Q16) / W_DIV;
    px     = '0;
    case (plane_mode)
      MODE_RED: begin
        px.red = red_lvl; px.green = row_ch; px.blue = col_ch;
      end
      MODE_GREEN: begin
        px.red = row_ch; px.green = green_lvl; px.blue = col_ch;
      end
      MODE_BLUE: begin
        px.red = row_ch; px.green = col_ch; px.blue = blue_lvl;
      end
      MODE_HUE: begin
        hue = (hue_deg > HUE_MAX) ? HUE_MAX : hue_deg;
        px  = hsv_colour((hue * UNIT_Q16) / HUE_STEP, col_q, row_q);
      end
      MODE_SAT:   px = hsv_colour(hp, (sat_lvl * UNIT_Q16) / CH_MAX, row_q);
      MODE_VALUE: px = hsv_colour(hp, row_q, (bright_lvl * UNIT_Q16) / CH_MAX);
      default:    px = '0;
    endcase
    return px;
  endfunction

  function automatic int unsigned pick_value(input int unsigned top);
    case ($urandom_range(3))
      0:       return 0;
      1:       return top;
      default: return $urandom_range(top);
    endcase
  endfunction

  // register copies follow every accepted write
  always @(posedge clk) begin
    if (rst) begin
      plane_mode <= '0;
      red_lvl    <= '0;
      green_lvl  <= '0;
      blue_lvl   <= '0;
      hue_deg    <= '0;
      sat_lvl    <= '0;
      bright_lvl <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:       plane_mode <= cfg_data[2:0];
        REG_RED:        red_lvl    <= cfg_data[7:0];
        REG_GREEN:      green_lvl  <= cfg_data[7:0];
        REG_BLUE:       blue_lvl   <= cfg_data[7:0];
        REG_HUE:        hue_deg    <= cfg_data;
        REG_SATURATION: sat_lvl    <= cfg_data[7:0];
        REG_BRIGHTNESS: bright_lvl <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin : check_colour
    pixel_t want;
    pixel_t got;
    string  chan [3];
    chan = '{"red", "green", "blue"};
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (colour_q.size() == 0) begin
        $display("%0t: unexpected item, expected none got %h", $time, got);
        mismatches++;
      end else begin
        want = colour_q.pop_front();
        colours_checked++;
        for (int k = 0; k < 3; k++) begin
          if (got[8*k +: 8] !== want[8*k +: 8]) begin
            $display("%0t: %s expected %0d got %0d", $time, chan[k],
                     want[8*k +: 8], got[8*k +: 8]);
            mismatches++;
          end
        end
      end
    end
  end

  // sink side: random stalls, plus one long hold counted here
  initial begin : sink
    int held;
    held          = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold && held < LONG_HOLD) begin
        m_axis_tready <= 1'b0;
        held++;
      end else begin
        if (!long_hold) held = 0;
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    writes_done++;
    @(negedge clk);
  endtask

  task automatic push_pixel(input logic [9:0] col, row, input logic typed,
                            input pixel_t typed_px);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, row, col};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    colour_q.push_back(typed ? typed_px : predict_colour(col, row));
    pixels_sent++;
    @(negedge clk);
  endtask

  // stop offering pixels and wait for every colour to come back
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (colour_q.size() != 0);
  endtask

  initial begin : stimulus
    bit         pixels_pending;
    logic [2:0] mode;
    pixel_t     typed_px;
    pixels_pending  = 1'b0;
    mismatches      = 0;
    colours_checked = 0;
    pixels_sent     = 0;
    writes_done     = 0;
    long_hold       = 1'b0;
    src_idle_pct    = 30;
    sink_stall_pct  = 30;
    rst             = 1'b1;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_WRITE) begin
        if (pixels_pending) quiesce();
        pixels_pending = 1'b0;
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        cfg_valid <= 1'b0;
        typed_px.red   = plan[i].red;
        typed_px.green = plan[i].green;
        typed_px.blue  = plan[i].blue;
        push_pixel(plan[i].col, plan[i].row, plan[i].typed, typed_px);
        pixels_pending = 1'b1;
      end
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      quiesce();
      mode = (seg < 6) ? 3'(seg) : 3'($urandom_range(7));
      write_reg(REG_MODE, 9'(mode));
      write_reg(REG_RED, 9'(pick_value(255)));
      write_reg(REG_GREEN, 9'(pick_value(255)));
      write_reg(REG_BLUE, 9'(pick_value(255)));
      write_reg(REG_HUE, 9'(pick_value(511)));
      write_reg(REG_SATURATION, 9'(pick_value(255)));
      write_reg(REG_BRIGHTNESS, 9'(pick_value(255)));
      cfg_valid <= 1'b0;
      case (seg % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 45; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 45; end
        default: begin src_idle_pct = 30; sink_stall_pct = 30; end
      endcase
      if (seg == 4) long_hold = 1'b1;
      repeat (SEG_ITEMS)
        push_pixel(10'($urandom_range(1023)), 10'($urandom_range(1023)), 1'b0, '0);
      long_hold = 1'b0;
    end

    quiesce();
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    $display("%0d pixels sent, %0d colours checked, %0d register writes", pixels_sent,
             colours_checked, writes_done);
    $display("covered all eight mode codes, plane corners, clamped coordinates and hue");
    if (mismatches == 0 && colours_checked == pixels_sent) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("%0t: timeout with %0d colours outstanding", $time, colour_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/cppg_pkg.sv
hw/rtl/cppg_cdiv.sv
hw/rtl/cppg_hsv.sv
hw/rtl/color_plane_palette_generator.sv
hw/rtl/cppg_checker.sv
tb/sv/tb_color_plane_palette_generator.sv
